// ----- design/zvc_pkg.sv -----
package zvc_pkg;

    // Field widths
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GROUP_W = 7;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned SHIFT_W = 6;

    // Group count at which a still-continued byte is an overlong error
    localparam logic [COUNT_W-1:0] LAST_GROUP = 4'd9;

    // Action codes
    localparam logic ACTION_ENCODE = 1'b0;
    localparam logic ACTION_DECODE = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_PENDING  = 2'd1,
        KIND_VALUE    = 2'd2,
        KIND_OVERLONG = 2'd3
    } kind_t;

    typedef struct packed {
        logic                 action;
        logic                 use_zigzag;
        logic [VALUE_W-1:0]   value_in;
        logic [BYTE_W-1:0]    byte_in;
    } item_t;

    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    byte_out;
        logic                 last;
        logic [VALUE_W-1:0]   value_out;
    } result_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_ENCODE
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // take the presented transaction
        logic enc_step;  // emit the next byte of the held encode value
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic enc_more;  // current encode source still has bits above the low 7-bit group
    } dp_status_t;

endpackage

// ----- design/zvc_ctrl.sv -----
module zvc_ctrl
    import zvc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_action,
    output logic       item_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    logic        slot_free;

    // Output register can take a new transaction this cycle
    assign slot_free = !result_valid_reg || result_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && slot_free && item_action == ACTION_ENCODE && status.enc_more)
                begin
                    state_next = ST_ENCODE;
                end
            end
            ST_ENCODE:
            begin
                if (slot_free && !status.enc_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = slot_free;
                cmd.accept = item_valid && slot_free;
            end
            ST_ENCODE:
            begin
                cmd.enc_step = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold the result until taken, load on any produced byte or decode result
    assign result_valid_next = cmd.accept || cmd.enc_step || (result_valid_reg && !result_ready);
    assign result_valid      = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

// ----- design/zvc_datapath.sv -----
module zvc_datapath
    import zvc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output result_t    result
);

    logic [VALUE_W-1:0] enc_shift_reg;
    logic [VALUE_W-1:0] enc_shift_next;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    result_t            result_reg;
    result_t            result_next;

    logic [VALUE_W-1:0] mapped_in;
    logic [VALUE_W-1:0] enc_src;
    logic               enc_more;
    logic [SHIFT_W-1:0] shift_amt;
    logic [VALUE_W-1:0] acc_merged;
    logic [VALUE_W-1:0] acc_unmapped;
    logic               dec_more;

    // Zigzag map of the incoming value
    assign mapped_in = item.use_zigzag
                     ? ((item.value_in << 1) ^ {VALUE_W{item.value_in[VALUE_W-1]}})
                     : item.value_in;

    // Encode source: fresh value on accept, remaining groups while stepping
    assign enc_src  = cmd.enc_step ? enc_shift_reg : mapped_in;
    assign enc_more = |enc_src[VALUE_W-1:GROUP_W];
    assign status.enc_more = enc_more;

    // Decode merge at shift 7 * count; upper group bits fall off the top
    assign shift_amt    = SHIFT_W'(({3'b000, count_reg} << 3) - {3'b000, count_reg});
    assign acc_merged   = acc_reg | ({{(VALUE_W-GROUP_W){1'b0}}, item.byte_in[GROUP_W-1:0]}
                                     << shift_amt);
    assign acc_unmapped = item.use_zigzag
                        ? ((acc_merged >> 1) ^ {VALUE_W{acc_merged[0]}})
                        : acc_merged;
    assign dec_more     = item.byte_in[BYTE_W-1];

    // Next values of the encode shifter, accumulator and result
    always_comb
    begin
        enc_shift_next = enc_shift_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        result_next    = result_reg;

        if (cmd.enc_step || (cmd.accept && item.action == ACTION_ENCODE))
        begin
            enc_shift_next        = enc_src >> GROUP_W;
            result_next.kind      = KIND_BYTE;
            result_next.byte_out  = {enc_more, enc_src[GROUP_W-1:0]};
            result_next.last      = !enc_more;
            result_next.value_out = '0;
        end
        else if (cmd.accept)
        begin
            result_next.byte_out  = '0;
            result_next.last      = 1'b1;
            result_next.value_out = '0;
            priority if (!dec_more)
            begin
                result_next.kind      = KIND_VALUE;
                result_next.value_out = acc_unmapped;
                acc_next              = '0;
                count_next            = '0;
            end
            else if (count_reg == LAST_GROUP)
            begin
                result_next.kind = KIND_OVERLONG;
                acc_next         = '0;
                count_next       = '0;
            end
            else
            begin
                result_next.kind = KIND_PENDING;
                acc_next         = acc_merged;
                count_next       = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        enc_shift_reg <= enc_shift_next;
        result_reg    <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- design/zigzag_varint_codec_core.sv -----
// Encode: one result byte per cycle while results are taken, 1 to 10 bytes per
// value (datapath 7-bit group shifter). First byte is registered on acceptance.
// Decode: one byte per cycle while results are taken, registered on acceptance.
// The output register frees a slot each cycle the result is taken.
// Reset (rst_n low, asynchronous) clears the accumulator, group count and state.
module zigzag_varint_codec_core
    import zvc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencing and output handshake
    zvc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_action  (item.action),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Group shifter, accumulator and result register
    zvc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// ----- sim/tb_zigzag_varint_codec_core.sv -----
`timescale 1ns / 1ps

module tb_zigzag_varint_codec_core
    import zvc_pkg::*;
();

    localparam int ITEM_TARGET   = 330;
    localparam int MAX_WAIT      = 11;
    localparam int RX_HOLD_START = 40;
    localparam int RX_HOLD_LEN   = 400;
    localparam int DRAIN_CYCLES  = 16;
    localparam int SHOW_LIMIT    = 100;

    // One row of stimulus; a typed row carries its single expected result
    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    // Decoder image kept by the predictor
    logic [VALUE_W-1:0] dec_acc    = '0;
    logic [COUNT_W-1:0] dec_groups = '0;

    stim_row_t stim[$];
    result_t   step_out[$];
    result_t   results_due[$];

    int mismatches     = 0;
    int accepted_items = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;
    logic rx_hold      = 1'b0;

    zigzag_varint_codec_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Append to the stimulus table, the per-step results and the expected results
    function automatic void add_stim(input stim_row_t r);
        stim.insert(stim.size(), r);
    endfunction

    function automatic void add_step(input result_t r);
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void book_result(input result_t r);
        results_due.insert(results_due.size(), r);
    endfunction

    function automatic result_t res(input kind_t k, input logic [BYTE_W-1:0] b,
                                    input logic l, input logic [VALUE_W-1:0] v);
        result_t r;
        r.kind      = k;
        r.byte_out  = b;
        r.last      = l;
        r.value_out = v;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] fold_signed(input logic [VALUE_W-1:0] v);
        return (v << 1) ^ {VALUE_W{v[VALUE_W-1]}};
    endfunction

    function automatic logic [VALUE_W-1:0] unfold_signed(input logic [VALUE_W-1:0] v);
        return (v >> 1) ^ {VALUE_W{v[0]}};
    endfunction

    // Compute the results of one accepted transaction into step_out
    function automatic void predict_codec(input item_t it);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] group;
        int                 shift;
        step_out.delete();
        if (it.action == ACTION_ENCODE)
        begin
            v = it.use_zigzag ? fold_signed(it.value_in) : it.value_in;
            while (v[VALUE_W-1:GROUP_W] != '0)
            begin
                add_step(res(KIND_BYTE, {1'b1, v[GROUP_W-1:0]}, 1'b0, '0));
                v = v >> GROUP_W;
            end
            add_step(res(KIND_BYTE, {1'b0, v[GROUP_W-1:0]}, 1'b1, '0));
        end
        else
        begin
            // Bits shifted past the top of the accumulator are dropped
            shift = int'(dec_groups) * GROUP_W;
            group = {{(VALUE_W-GROUP_W){1'b0}}, it.byte_in[GROUP_W-1:0]};
            dec_acc = dec_acc | (group << shift);
            if (!it.byte_in[BYTE_W-1])
            begin
                v = it.use_zigzag ? unfold_signed(dec_acc) : dec_acc;
                add_step(res(KIND_VALUE, '0, 1'b1, v));
                dec_acc    = '0;
                dec_groups = '0;
            end
            else if (dec_groups == LAST_GROUP)
            begin
                add_step(res(KIND_OVERLONG, '0, 1'b1, '0));
                dec_acc    = '0;
                dec_groups = '0;
            end
            else
            begin
                add_step(res(KIND_PENDING, '0, 1'b1, '0));
                dec_groups = dec_groups + 1'b1;
            end
        end
    endfunction

    function automatic stim_row_t enc_row(input logic zz, input logic [VALUE_W-1:0] v,
                                          input logic typed, input result_t want);
        stim_row_t r;
        r.it.action     = ACTION_ENCODE;
        r.it.use_zigzag = zz;
        r.it.value_in   = v;
        r.it.byte_in    = BYTE_W'($urandom);
        r.typed         = typed;
        r.want          = want;
        return r;
    endfunction

    function automatic stim_row_t dec_row(input logic zz, input logic [BYTE_W-1:0] b,
                                          input logic typed, input result_t want);
        stim_row_t r;
        r.it.action     = ACTION_DECODE;
        r.it.use_zigzag = zz;
        r.it.value_in   = {$urandom, $urandom};
        r.it.byte_in    = b;
        r.typed         = typed;
        r.want          = want;
        return r;
    endfunction

    // Spread encode lengths evenly; fold some values to small negatives
    function automatic logic [VALUE_W-1:0] rand_value(input logic zz);
        logic [VALUE_W-1:0] v;
        int                 bits;
        v    = {$urandom, $urandom};
        bits = $urandom_range(0, VALUE_W);
        if (bits < VALUE_W)
            v = v & ((64'd1 << bits) - 64'd1);
        if (zz && $urandom_range(0, 1) == 1)
            v = ~v;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < SHOW_LIMIT)
            $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d byte %02h value %016h",
                                      got.kind, got.byte_out, got.value_out));
            return;
        end
        want = results_due.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.byte_out !== want.byte_out)
            report_mismatch($sformatf("byte_out got %02h want %02h",
                                      got.byte_out, want.byte_out));
        if (got.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
        if (got.value_out !== want.value_out)
            report_mismatch($sformatf("value_out got %016h want %016h",
                                      got.value_out, want.value_out));
    endtask

    // Offer one transaction after a random gap and book its results on acceptance
    task automatic send_row(input stim_row_t r);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= r.it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_codec(r.it);
        if (r.typed)
            book_result(r.want);
        else
            foreach (step_out[k])
                book_result(step_out[k]);
        accepted_items++;
    endtask

    // Main sequence: reset, directed table, random traffic, drain
    initial
    begin
        int         pick;
        int         len;
        logic       zz;
        logic [7:0] b;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        add_stim(dec_row(1'b1, 8'h01, 1'b1, res(KIND_VALUE, '0, 1'b1, '1)));
        add_stim(enc_row(1'b1, '0, 1'b1, res(KIND_BYTE, 8'h00, 1'b1, '0)));
        add_stim(enc_row(1'b0, '1, 1'b0, '0));
        add_stim(enc_row(1'b1, '1, 1'b1, res(KIND_BYTE, 8'h01, 1'b1, '0)));
        // Top group overflow, with an encode in the middle of the value
        add_stim(dec_row(1'b0, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b0, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(enc_row(1'b1, 64'h8000_0000_0000_0000, 1'b0, '0));
        add_stim(dec_row(1'b0, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b0, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b0, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b0, 8'h7F, 1'b1, res(KIND_VALUE, '0, 1'b1, '1)));
        // Overlong run of ten continued bytes
        add_stim(dec_row(1'b0, 8'h80, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b0, 8'h80, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b0, 8'h80, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b0, 8'h80, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'hFF, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b0, 8'h80, 1'b1, res(KIND_PENDING, '0, 1'b1, '0)));
        add_stim(dec_row(1'b1, 8'h80, 1'b1, res(KIND_OVERLONG, '0, 1'b1, '0)));

        // Random part: mostly encodes and well-formed byte runs, some noise
        while (stim.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            zz   = 1'($urandom_range(0, 1));
            if (pick < 40)
            begin
                add_stim(enc_row(zz, rand_value(zz), 1'b0, '0));
            end
            else if (pick < 82)
            begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                begin
                    b    = 8'($urandom);
                    b[7] = (k < len - 1);
                    add_stim(dec_row(1'($urandom_range(0, 1)), b, 1'b0, '0));
                    if (k < len - 1 && $urandom_range(0, 7) == 0)
                        add_stim(enc_row(zz, rand_value(zz), 1'b0, '0));
                end
            end
            else if (pick < 90)
            begin
                for (int k = 0; k < 10; k++)
                begin
                    b    = 8'($urandom);
                    b[7] = 1'b1;
                    add_stim(dec_row(1'($urandom_range(0, 1)), b, 1'b0, '0));
                end
            end
            else
            begin
                b = 8'($urandom);
                add_stim(dec_row(zz, b, 1'b0, '0));
            end
        end

        // Walk the table
        for (int i = 0; i < stim.size(); i++)
            send_row(stim[i]);
        item_valid <= 1'b0;

        // Drain, then allow the tail of the pipeline to settle
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[zigzag_varint_codec_core] OK");
        else
            $display("[zigzag_varint_codec_core] ERROR");
        $finish;
    end

    // Receiver: random ready gaps, long hold while rx_hold is set
    initial
    begin
        int gap;
        result_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0 || rx_hold)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (rx_hold)
                    @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            check_result(result);
        end
    end

    // Hold off the receiver for a long stretch so the input backs up
    initial
    begin
        wait (accepted_items >= RX_HOLD_START);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_LEN) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[zigzag_varint_codec_core] ERROR");
        $finish;
    end

endmodule
